FILE: sv/brfifo_pkg.sv
package brfifo_pkg;

	// Storage geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CNT_W:0]        sum_t;
	typedef logic [4:0]            cap_t;
	typedef logic [4:0]            cnt_out_t;
	typedef logic [31:0]           word_t;

	localparam cap_t CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_PEEK  = 2'd1,
		OP_POLL  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic cfg_wr;
	} dp_ctl_t;

endpackage

FILE: sv/bounded_ring_fifo_unit.sv
// Ring-buffer FIFO of 16 words of 32 bits driven by commands: add, peek, poll
// and clear, each answered by one result with status, head word, count and
// empty/full flags. A command is accepted while the controller is idle, which
// also launches the registered read of the head slot, and it executes once the
// output register is free, updating the pointers, writing the tail slot and
// loading the output register; a new command is accepted only after the previous
// one has executed. Writing capacity_in_use (0 means full depth) empties the
// queue and is taken only while no command runs.
module bounded_ring_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] head_value,
	output logic [4:0]  item_count,
	output logic        empty_flag,
	output logic        full_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  capacity_in_use
);

	brfifo_pkg::dp_ctl_t ctl;

	// Sequencer
	brfifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// Storage, pointers and result register
	brfifo_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cmd             (cmd),
		.item_value      (item_value),
		.capacity_in_use (capacity_in_use),
		.status          (status),
		.head_value      (head_value),
		.item_count      (item_count),
		.empty_flag      (empty_flag),
		.full_flag       (full_flag)
	);

endmodule

FILE: sv/brfifo_dp.sv
module brfifo_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  brfifo_pkg::dp_ctl_t   ctl,
	input  logic [1:0]            cmd,
	input  logic [31:0]           item_value,
	input  logic [4:0]            capacity_in_use,
	output logic [1:0]            status,
	output logic [31:0]           head_value,
	output logic [4:0]            item_count,
	output logic                  empty_flag,
	output logic                  full_flag
);

	brfifo_pkg::data_t   mem [brfifo_pkg::DEPTH];
	brfifo_pkg::cap_t    cap_q;
	brfifo_pkg::ptr_t    head_q;
	brfifo_pkg::cnt_t    count_q;
	brfifo_pkg::op_t     op_s1;
	brfifo_pkg::data_t   item_s1;
	brfifo_pkg::data_t   rd_s1;

	brfifo_pkg::cnt_t    act_cap;
	brfifo_pkg::cnt_t    head_inc;
	brfifo_pkg::sum_t    tail_sum;
	brfifo_pkg::ptr_t    tail;
	brfifo_pkg::ptr_t    head_nxt;
	brfifo_pkg::cnt_t    count_nxt;
	brfifo_pkg::status_t status_nxt;
	brfifo_pkg::data_t   head_nxt_val;
	logic                wr_en;

	// Resolve the capacity in use: zero or oversize selects full depth
	always_comb begin
		if (cap_q == '0 || 32'(cap_q) > brfifo_pkg::DEPTH) begin
			act_cap = brfifo_pkg::cnt_t'(brfifo_pkg::DEPTH);
		end else begin
			act_cap = brfifo_pkg::cnt_t'(cap_q);
		end
	end

	// Wrap the tail and next head pointers at the capacity
	always_comb begin
		head_inc = brfifo_pkg::cnt_t'(head_q) + brfifo_pkg::cnt_t'(1);
		head_nxt = (head_inc == act_cap) ? '0 : brfifo_pkg::ptr_t'(head_inc);
		tail_sum = brfifo_pkg::sum_t'(head_q) + brfifo_pkg::sum_t'(count_q);
		if (tail_sum >= brfifo_pkg::sum_t'(act_cap)) begin
			tail_sum = tail_sum - brfifo_pkg::sum_t'(act_cap);
		end
		tail = brfifo_pkg::ptr_t'(tail_sum);
	end

	// Decode the held command
	always_comb begin
		status_nxt   = brfifo_pkg::ST_OK;
		head_nxt_val = '0;
		count_nxt    = count_q;
		wr_en        = 1'b0;
		unique case (op_s1)
			brfifo_pkg::OP_ADD: begin
				if (count_q == act_cap) begin
					status_nxt = brfifo_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + brfifo_pkg::cnt_t'(1);
				end
			end
			brfifo_pkg::OP_PEEK, brfifo_pkg::OP_POLL: begin
				if (count_q == '0) begin
					status_nxt = brfifo_pkg::ST_EMPTY;
				end else begin
					head_nxt_val = rd_s1;
					if (op_s1 == brfifo_pkg::OP_POLL) begin
						count_nxt = count_q - brfifo_pkg::cnt_t'(1);
					end
				end
			end
			brfifo_pkg::OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	// Capacity register and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= brfifo_pkg::CAP_RESET;
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.cfg_wr) begin
			cap_q   <= capacity_in_use;
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= count_nxt;
			if (op_s1 == brfifo_pkg::OP_CLEAR) begin
				head_q <= '0;
			end else if (op_s1 == brfifo_pkg::OP_POLL && count_q != '0) begin
				head_q <= head_nxt;
			end
		end
	end

	// Slot memory: read the head on accept, write the tail on execute
	always_ff @(posedge clk) begin
		if (wr_en && ctl.exec) begin
			mem[tail] <= item_s1;
		end
		if (ctl.load) begin
			rd_s1 <= mem[head_q];
		end
	end

	// Hold the accepted command
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_s1   <= brfifo_pkg::op_t'(cmd);
			item_s1 <= brfifo_pkg::data_t'(item_value);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status     <= status_nxt;
			head_value <= brfifo_pkg::word_t'(head_nxt_val);
			item_count <= brfifo_pkg::cnt_out_t'(count_nxt);
			empty_flag <= (count_nxt == '0);
			full_flag  <= (count_nxt == act_cap);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= act_cap)
		else $error("fill count exceeds capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brfifo_pkg::cnt_t'(head_q) < act_cap)
		else $error("head pointer beyond capacity");

	a_full_add_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && op_s1 == brfifo_pkg::OP_ADD && count_q == act_cap
		|=> $stable(count_q) && $stable(head_q))
		else $error("refused add changed queue state");
`endif

endmodule

FILE: sv/brfifo_ctrl.sv
module brfifo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output brfifo_pkg::dp_ctl_t ctl
);

	brfifo_pkg::state_t state_q;
	brfifo_pkg::state_t state_nxt;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			brfifo_pkg::S_IDLE: begin
				if (in_valid && !cfg_valid) begin
					state_nxt = brfifo_pkg::S_EXEC;
				end
			end
			brfifo_pkg::S_EXEC: begin
				if (out_free) begin
					state_nxt = brfifo_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = brfifo_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_stall   = 1'b1;
		cfg_ready  = 1'b0;
		ctl.load   = 1'b0;
		ctl.exec   = 1'b0;
		ctl.cfg_wr = 1'b0;
		unique case (state_q)
			brfifo_pkg::S_IDLE: begin
				in_stall   = cfg_valid;
				cfg_ready  = 1'b1;
				ctl.load   = in_valid && !cfg_valid;
				ctl.cfg_wr = cfg_valid;
			end
			brfifo_pkg::S_EXEC: begin
				ctl.exec = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brfifo_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: bench/tb_bounded_ring_fifo_unit.sv
`timescale 1ns / 1ps

module tb_bounded_ring_fifo_unit;
	import brfifo_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 153;

	typedef struct packed {
		status_t  st;
		word_t    head;
		cnt_out_t cnt;
		logic     empty;
		logic     full;
	} fifo_result_t;

	typedef struct packed {
		logic         is_cfg;
		cap_t         cap;
		op_t          op;
		word_t        value;
		logic         typed;
		fifo_result_t res;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [31:0] item_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] head_value;
	logic [4:0]  item_count;
	logic        empty_flag;
	logic        full_flag;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  capacity_in_use = '0;

	// Shadow copy of the ring and its pointers
	data_t       ring [DEPTH];
	int unsigned ring_head;
	int unsigned ring_fill;
	cap_t        cap_reg;

	fifo_result_t pending_results [$];
	plan_row_t    directed_plan [$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	int           items_sent = 0;
	bit           quiet = 1'b0;

	bounded_ring_fifo_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.item_value     (item_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.head_value     (head_value),
		.item_count     (item_count),
		.empty_flag     (empty_flag),
		.full_flag      (full_flag),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_in_use(capacity_in_use)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want_v);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want_v);
	endtask

	// Apply one command to the shadow ring and return the result it must give
	function automatic fifo_result_t apply_command(op_t op, word_t v);
		fifo_result_t r;
		int unsigned  cap;
		cap = (cap_reg == 0 || cap_reg > DEPTH) ? DEPTH : cap_reg;
		r = '0;
		r.st = ST_OK;
		case (op)
			OP_ADD: begin
				if (ring_fill == cap) begin
					r.st = ST_FULL;
				end else begin
					ring[(ring_head + ring_fill) % cap] = v;
					ring_fill++;
				end
			end
			OP_PEEK, OP_POLL: begin
				if (ring_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.head = ring[ring_head];
					if (op == OP_POLL) begin
						ring_head = (ring_head + 1) % cap;
						ring_fill--;
					end
				end
			end
			default: begin
				ring_head = 0;
				ring_fill = 0;
			end
		endcase
		r.cnt   = cnt_out_t'(ring_fill);
		r.empty = (ring_fill == 0);
		r.full  = (ring_fill == cap);
		return r;
	endfunction

	function automatic plan_row_t cmd_row(op_t op, word_t v, bit typed, status_t st,
			word_t hd, int cnt, bit e, bit f);
		plan_row_t p;
		p = '0;
		p.op = op;
		p.value = v;
		p.typed = typed;
		p.res.st = st;
		p.res.head = hd;
		p.res.cnt = cnt_out_t'(cnt);
		p.res.empty = e;
		p.res.full = f;
		return p;
	endfunction

	function automatic plan_row_t cfg_row(cap_t c);
		plan_row_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.cap = c;
		return p;
	endfunction

	// Present one command, hold it until taken, then queue its expected result
	task automatic run_command(op_t op, word_t v, bit typed, fifo_result_t typed_res);
		fifo_result_t predicted;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		item_value = v;
		do @(posedge clk); while (in_stall);
		predicted = apply_command(op, v);
		pending_results.push_back(typed ? typed_res : predicted);
		items_sent++;
	endtask

	// Drain all results, then write the capacity register
	task automatic write_capacity(cap_t c);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		capacity_in_use = c;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = c;
		ring_head = 0;
		ring_fill = 0;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random stall on the result side
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 8);
	end

	// Check each taken result against the oldest expectation
	always @(posedge clk) begin
		fifo_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, status", status, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) report_mismatch("status", status, want.st);
				if (head_value !== want.head) report_mismatch("head_value", head_value, want.head);
				if (item_count !== want.cnt) report_mismatch("item_count", item_count, want.cnt);
				if (empty_flag !== want.empty) report_mismatch("empty_flag", empty_flag, want.empty);
				if (full_flag !== want.full) report_mismatch("full_flag", full_flag, want.full);
			end
		end
	end

	// Stop a hung run: count cycles with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		cap_t  phase_caps [8];
		cap_t  c;
		op_t   op;
		word_t v;
		int    r;
		int    sel;
		bit    filling;

		phase_caps = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8};
		cap_reg = CAP_RESET;
		ring_head = 0;
		ring_fill = 0;
		filling = 1'b1;

		// Directed commands: empty refusals, extremes of the word, full refusal,
		// capacity zero and capacity above depth
		directed_plan.push_back(cmd_row(OP_PEEK, 32'h0, 1, ST_EMPTY, 32'h0, 0, 1, 0));
		directed_plan.push_back(cmd_row(OP_POLL, 32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 0, 1, 0));
		directed_plan.push_back(cmd_row(OP_ADD, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 1, 0, 0));
		directed_plan.push_back(cmd_row(OP_ADD, 32'h0, 1, ST_OK, 32'h0, 2, 0, 0));
		directed_plan.push_back(cmd_row(OP_PEEK, 32'h0, 1, ST_OK, 32'hFFFF_FFFF, 2, 0, 0));
		directed_plan.push_back(cmd_row(OP_POLL, 32'h0, 1, ST_OK, 32'hFFFF_FFFF, 1, 0, 0));
		directed_plan.push_back(cmd_row(OP_POLL, 32'h0, 1, ST_OK, 32'h0, 0, 1, 0));
		directed_plan.push_back(cmd_row(OP_CLEAR, 32'h0, 1, ST_OK, 32'h0, 0, 1, 0));
		directed_plan.push_back(cfg_row(5'd1));
		directed_plan.push_back(cmd_row(OP_ADD, 32'hA5A5_A5A5, 1, ST_OK, 32'h0, 1, 0, 1));
		directed_plan.push_back(cmd_row(OP_ADD, 32'h5A5A_5A5A, 1, ST_FULL, 32'h0, 1, 0, 1));
		directed_plan.push_back(cmd_row(OP_POLL, 32'h0, 1, ST_OK, 32'hA5A5_A5A5, 0, 1, 0));
		directed_plan.push_back(cfg_row(5'd2));
		directed_plan.push_back(cmd_row(OP_ADD, 32'h1234_5678, 1, ST_OK, 32'h0, 1, 0, 0));
		directed_plan.push_back(cmd_row(OP_ADD, 32'h8765_4321, 1, ST_OK, 32'h0, 2, 0, 1));
		directed_plan.push_back(cmd_row(OP_ADD, 32'hDEAD_BEEF, 1, ST_FULL, 32'h0, 2, 0, 1));
		directed_plan.push_back(cmd_row(OP_POLL, 32'h0, 0, ST_OK, 32'h0, 0, 0, 0));
		directed_plan.push_back(cmd_row(OP_ADD, 32'hCAFE_F00D, 0, ST_OK, 32'h0, 0, 0, 0));
		directed_plan.push_back(cmd_row(OP_CLEAR, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 0, 1, 0));
		directed_plan.push_back(cfg_row(5'd31));
		directed_plan.push_back(cmd_row(OP_ADD, 32'h0F0F_0F0F, 1, ST_OK, 32'h0, 1, 0, 0));
		directed_plan.push_back(cmd_row(OP_PEEK, 32'h0, 1, ST_OK, 32'h0F0F_0F0F, 1, 0, 0));
		directed_plan.push_back(cfg_row(5'd0));
		directed_plan.push_back(cmd_row(OP_ADD, 32'hF0F0_F0F0, 1, ST_OK, 32'h0, 1, 0, 0));

		// Hold reset, then release at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg)
				write_capacity(directed_plan[i].cap);
			else
				run_command(directed_plan[i].op, directed_plan[i].value,
					directed_plan[i].typed, directed_plan[i].res);
		end

		// Random phases: swing between filling and draining so both ends are hit
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			c = (ph < 8) ? phase_caps[ph] : cap_t'($urandom_range(0, 31));
			write_capacity(c);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				quiet = (items_sent >= 700 && items_sent < 950);
				if ($urandom_range(0, 29) == 0) filling = !filling;
				r = $urandom_range(0, 99);
				if (r < 3)
					op = OP_CLEAR;
				else if (r < (filling ? 68 : 23))
					op = OP_ADD;
				else if (r < (filling ? 80 : 45))
					op = OP_PEEK;
				else
					op = OP_POLL;
				sel = $urandom_range(0, 15);
				v = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : word_t'($urandom);
				run_command(op, v, 1'b0, '0);
			end
		end
		quiet = 1'b0;

		// Drop valid, drain, and watch for stray results
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
